>>> rtl/core/plics_pkg.sv
// Shared constants and codes for the interface segment pipeline.
// No dependencies; imported by the top level.
package plics_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    // result status codes
    localparam logic [1:0] ST_SKIP = 2'd0;
    localparam logic [1:0] ST_SEG  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    typedef enum logic [2:0] {
        K_SKIP,
        K_ZERO,
        K_AXH,
        K_AXV,
        K_DIAG
    } t_kind;

    typedef enum logic [1:0] {
        CASE_I,
        CASE_II,
        CASE_III
    } t_case;

    typedef enum logic [1:0] {
        Q1,
        Q2,
        Q3,
        Q4
    } t_quad;

endpackage

>>> rtl/core/plics_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Standalone; used by plic_interface_segment.
module plics_div #(
    parameter int DW = 20,
    parameter int QW = 32
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DW+QW-1:0] i_num,
    input  logic [DW-1:0]    i_den,
    output logic [QW-1:0]    o_q
);

    logic [DW-1:0] r_rem [QW-1];
    logic [QW-1:0] r_num [QW-1];
    logic [DW-1:0] r_den [QW-1];
    logic [QW-1:0] r_q   [QW];

    for (genvar j = 0; j < QW; j++) begin : g_st
        logic [DW-1:0] c_rem;
        logic [QW-1:0] c_num;
        logic [DW-1:0] c_den;
        logic [QW-1:0] c_q;
        logic [DW:0]   c_t;
        logic          c_ge;

        if (j == 0) begin : g_first
            assign c_rem = i_num[DW+QW-1:QW];
            assign c_num = i_num[QW-1:0];
            assign c_den = i_den;
            assign c_q   = '0;
        end else begin : g_next
            assign c_rem = r_rem[j-1];
            assign c_num = r_num[j-1];
            assign c_den = r_den[j-1];
            assign c_q   = r_q[j-1];
        end

        assign c_t  = {c_rem, c_num[QW-1]};
        assign c_ge = c_t >= {1'b0, c_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[j] <= {c_q[QW-2:0], c_ge};
            end
        end

        if (j < QW - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= c_ge ? DW'(c_t - {1'b0, c_den}) : c_t[DW-1:0];
                    r_num[j] <= c_num << 1;
                    r_den[j] <= c_den;
                end
            end
        end
    end

    assign o_q = r_q[QW-1];

endmodule

>>> rtl/core/plics_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Standalone; used by plic_interface_segment.
module plics_sqrt #(
    parameter int OW = 17
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*OW-2:0] i_rad,
    output logic [OW-1:0]   o_root
);

    localparam int RW = 2 * OW - 1;
    localparam int TW = RW + 2;

    logic [RW-1:0] r_rem  [OW-1];
    logic [OW-1:0] r_root [OW];

    for (genvar j = 0; j < OW; j++) begin : g_st
        localparam int BI = OW - 1 - j;
        logic [RW-1:0] c_rem;
        logic [OW-1:0] c_root;
        logic [TW-1:0] c_trial;
        logic          c_ge;

        if (j == 0) begin : g_first
            assign c_rem  = i_rad;
            assign c_root = '0;
        end else begin : g_next
            assign c_rem  = r_rem[j-1];
            assign c_root = r_root[j-1];
        end

        // (root + 2^b)^2 - root^2 = root*2^(b+1) + 2^(2b)
        assign c_trial = (TW'(c_root) << (BI + 1)) + (TW'(1) << (2 * BI));
        assign c_ge    = TW'(c_rem) >= c_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[j] <= c_ge ? (c_root | (OW'(1) << BI)) : c_root;
            end
        end

        if (j < OW - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= c_ge ? RW'(TW'(c_rem) - c_trial) : c_rem;
                end
            end
        end
    end

    assign o_root = r_root[OW-1];

endmodule

>>> rtl/core/plic_interface_segment.sv
// Top level: piecewise-linear interface segment for one cell per request.
// Depends on plics_pkg, plics_div and plics_sqrt.
//
//  channel   dir  handshake                      payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  9 fractions, cell width, height
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  status (tuser), 4 offsets (tdata)
//
// One request enters per cycle while the output is not stalled; results leave in order,
// one per request. The pipe has five front stages, 2*FRACTION_BITS divider stages,
// FRACTION_BITS+1 root stages and two output stages.
// i_rst_n (synchronous, active low) clears only the valid bits.
// A stall at the output freezes the whole pipe; nothing is dropped or repeated.
module plic_interface_segment #(
    parameter int FRACTION_BITS = plics_pkg::FRACTION_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // low to high: frac_centre, frac_east, frac_west, frac_north, frac_south,
    // frac_northeast, frac_northwest, frac_southeast, frac_southwest,
    // cell_width, cell_height (FRACTION_BITS+1 bits each), zero pad
    input  logic [((11*(FRACTION_BITS+1)+7)/8)*8-1:0] i_s_axis_tdata,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // low to high: first_x, first_y, second_x, second_y
    // (FRACTION_BITS+2 bits each, signed), zero pad
    output logic [((4*(FRACTION_BITS+2)+7)/8)*8-1:0] o_m_axis_tdata,
    // status
    output logic [1:0] o_m_axis_tuser
);

    import plics_pkg::*;

    localparam int F   = FRACTION_BITS;
    localparam int FW  = F + 1;
    localparam int SW  = F + 4;          // signed gradient sums
    localparam int MW  = F + 3;          // gradient magnitudes
    localparam int PW  = 2 * F + 4;      // 2*x*n products
    localparam int DW  = F + 4;          // divisor
    localparam int QW  = 2 * F;          // quotient
    localparam int NW  = DW + QW;        // numerator
    localparam int OW  = F + 1;          // root
    localparam int RW  = 2 * OW - 1;     // radicand
    localparam int EW  = F + 2;          // output offsets
    localparam int ODW = ((4 * EW + 7) / 8) * 8;
    localparam int NS  = 7 + QW + OW;    // pipeline stages

    localparam logic [F:0] U1 = FW'(1) << F;

    typedef struct packed {
        t_kind      kind;
        t_quad      quad;
        t_case      cse;
        logic       tlt;
        logic       sx_pos;
        logic       sy_pos;
        logic       sat_a;
        logic       sat_b;
        logic [F:0] ph;
        logic [F:0] w;
        logic [F:0] h;
    } t_ctx;

    typedef logic [3:0][F:0] t_pos;

    logic          adv;
    logic [NS:1]   r_vld;

    assign adv             = !r_vld[NS] || i_m_axis_tready;
    assign o_s_axis_tready = adv;
    assign o_m_axis_tvalid = r_vld[NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NS-1:1], i_s_axis_tvalid};
        end
    end

    // ---- stage 1: clamp fractions, Sobel sums
    logic [F:0] c1_f [9];
    logic [MW-1:0] c1_px, c1_nx, c1_py, c1_ny;

    for (genvar i = 0; i < 9; i++) begin : g_clamp
        logic [F:0] c_raw;
        assign c_raw   = i_s_axis_tdata[i*FW +: FW];
        assign c1_f[i] = (c_raw > U1) ? U1 : c_raw;
    end

    // 0 c, 1 e, 2 w, 3 n, 4 s, 5 ne, 6 nw, 7 se, 8 sw
    assign c1_px = MW'(c1_f[5]) + (MW'(c1_f[1]) << 1) + MW'(c1_f[7]);
    assign c1_nx = MW'(c1_f[6]) + (MW'(c1_f[2]) << 1) + MW'(c1_f[8]);
    assign c1_py = MW'(c1_f[5]) + (MW'(c1_f[3]) << 1) + MW'(c1_f[6]);
    assign c1_ny = MW'(c1_f[7]) + (MW'(c1_f[4]) << 1) + MW'(c1_f[8]);

    logic signed [SW-1:0] r1_sx, r1_sy;
    logic [F:0]           r1_ph, r1_w, r1_h;
    logic                 r1_skip;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_sx   <= $signed({1'b0, c1_px}) - $signed({1'b0, c1_nx});
            r1_sy   <= $signed({1'b0, c1_py}) - $signed({1'b0, c1_ny});
            r1_ph   <= c1_f[0];
            r1_w    <= i_s_axis_tdata[9*FW +: FW];
            r1_h    <= i_s_axis_tdata[10*FW +: FW];
            r1_skip <= (c1_f[0] == '0) || (c1_f[0] >= U1);
        end
    end

    // ---- stage 2: magnitudes, slope ratio terms, quadrant, kind
    logic [MW-1:0] c2_ax, c2_ay, c2_tn, c2_td;
    logic          c2_sxp, c2_syp, c2_sxz, c2_syz, c2_agree;
    t_kind         c2_kind;
    t_quad         c2_quad;

    assign c2_ax    = r1_sx[SW-1] ? MW'(-r1_sx) : MW'(r1_sx);
    assign c2_ay    = r1_sy[SW-1] ? MW'(-r1_sy) : MW'(r1_sy);
    assign c2_sxz   = r1_sx == '0;
    assign c2_syz   = r1_sy == '0;
    assign c2_sxp   = !r1_sx[SW-1] && !c2_sxz;
    assign c2_syp   = !r1_sy[SW-1] && !c2_syz;
    assign c2_agree = c2_sxp == c2_syp;
    assign c2_tn    = c2_agree ? c2_ay : c2_ax;
    assign c2_td    = c2_agree ? c2_ax : c2_ay;

    always_comb begin
        if (r1_skip)                c2_kind = K_SKIP;
        else if (c2_sxz && c2_syz)  c2_kind = K_ZERO;
        else if (c2_sxz)            c2_kind = K_AXH;
        else if (c2_syz)            c2_kind = K_AXV;
        else                        c2_kind = K_DIAG;
        if (c2_sxp)                 c2_quad = c2_syp ? Q1 : Q4;
        else                        c2_quad = c2_syp ? Q2 : Q3;
    end

    t_kind         r2_kind;
    t_quad         r2_quad;
    logic [MW-1:0] r2_tn, r2_td, r2_mn, r2_mx;
    logic          r2_tlt, r2_sxp, r2_syp;
    logic [F:0]    r2_ph, r2_w, r2_h;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_kind <= c2_kind;
            r2_quad <= c2_quad;
            r2_tn   <= c2_tn;
            r2_td   <= c2_td;
            r2_tlt  <= c2_tn < c2_td;
            r2_mn   <= (c2_tn < c2_td) ? c2_tn : c2_td;
            r2_mx   <= (c2_tn < c2_td) ? c2_td : c2_tn;
            r2_sxp  <= c2_sxp;
            r2_syp  <= c2_syp;
            r2_ph   <= r1_ph;
            r2_w    <= r1_w;
            r2_h    <= r1_h;
        end
    end

    // ---- stage 3: Rudman case split
    localparam int CW = 2 * F + 5;
    logic [F:0]    c3_e;
    logic [CW-1:0] c3_m1, c3_m2, c3_mnu;
    logic          c3_i, c3_ii;

    assign c3_e   = U1 - r2_ph;
    assign c3_m1  = CW'(r2_ph) * CW'(r2_mx);
    assign c3_m2  = CW'(c3_e) * CW'(r2_mx);
    assign c3_mnu = CW'(r2_mn) << F;
    assign c3_i   = (c3_m1 << 1) <= c3_mnu;
    assign c3_ii  = !c3_i && ((c3_m2 << 1) >= c3_mnu);

    t_kind         r3_kind;
    t_quad         r3_quad;
    t_case         r3_cse;
    logic [MW-1:0] r3_tn, r3_td, r3_mn, r3_mx;
    logic          r3_tlt, r3_sxp, r3_syp;
    logic [F:0]    r3_ph, r3_w, r3_h, r3_x;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_kind <= r2_kind;
            r3_quad <= r2_quad;
            r3_cse  <= c3_i ? CASE_I : (c3_ii ? CASE_II : CASE_III);
            r3_x    <= c3_i ? r2_ph : c3_e;
            r3_tn   <= r2_tn;
            r3_td   <= r2_td;
            r3_mn   <= r2_mn;
            r3_mx   <= r2_mx;
            r3_tlt  <= r2_tlt;
            r3_sxp  <= r2_sxp;
            r3_syp  <= r2_syp;
            r3_ph   <= r2_ph;
            r3_w    <= r2_w;
            r3_h    <= r2_h;
        end
    end

    // ---- stage 4: leg products 2*x*n
    t_kind         r4_kind;
    t_quad         r4_quad;
    t_case         r4_cse;
    logic [PW-1:0] r4_pa, r4_pb;
    logic [MW-1:0] r4_tn, r4_td, r4_mn, r4_mx;
    logic          r4_tlt, r4_sxp, r4_syp;
    logic [F:0]    r4_ph, r4_w, r4_h;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_pa   <= (PW'(r3_x) * PW'(r3_tn)) << 1;
            r4_pb   <= (PW'(r3_x) * PW'(r3_td)) << 1;
            r4_kind <= r3_kind;
            r4_quad <= r3_quad;
            r4_cse  <= r3_cse;
            r4_tn   <= r3_tn;
            r4_td   <= r3_td;
            r4_mn   <= r3_mn;
            r4_mx   <= r3_mx;
            r4_tlt  <= r3_tlt;
            r4_sxp  <= r3_sxp;
            r4_syp  <= r3_syp;
            r4_ph   <= r3_ph;
            r4_w    <= r3_w;
            r4_h    <= r3_h;
        end
    end

    // ---- stage 5: saturation test, divider operands
    // quotient reaches UNIT^2 exactly when 2*x*n >= d*UNIT
    logic          c5_ii;
    logic [NW-1:0] r5_num_a, r5_num_b;
    logic [DW-1:0] r5_den_a, r5_den_b;
    t_ctx          r_ctx [QW+OW+1];
    logic [F:0]    r_hw  [OW];

    assign c5_ii = r4_cse == CASE_II;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_num_a <= c5_ii ? (NW'(r4_mn) << F) : (NW'(r4_pa) << F);
            r5_den_a <= c5_ii ? (DW'(r4_mx) << 1) : DW'(r4_td);
            r5_num_b <= NW'(r4_pb) << F;
            r5_den_b <= DW'(r4_tn);
            r_ctx[0] <= '{kind:   r4_kind,
                          quad:   r4_quad,
                          cse:    r4_cse,
                          tlt:    r4_tlt,
                          sx_pos: r4_sxp,
                          sy_pos: r4_syp,
                          sat_a:  r4_pa >= (PW'(r4_td) << F),
                          sat_b:  r4_pb >= (PW'(r4_tn) << F),
                          ph:     r4_ph,
                          w:      r4_w,
                          h:      r4_h};
        end
    end

    for (genvar k = 1; k <= QW + OW; k++) begin : g_ctx
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_ctx[k] <= r_ctx[k-1];
            end
        end
    end

    // ---- divide, then root
    logic [QW-1:0] w_q_a, w_q_b;
    logic [RW-1:0] c_rad_a, c_rad_b;
    logic [OW-1:0] w_s_a, w_s_b;

    plics_div #(.DW(DW), .QW(QW)) u_div_a (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r5_num_a),
        .i_den (r5_den_a),
        .o_q   (w_q_a)
    );

    plics_div #(.DW(DW), .QW(QW)) u_div_b (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r5_num_b),
        .i_den (r5_den_b),
        .o_q   (w_q_b)
    );

    assign c_rad_a = r_ctx[QW].sat_a ? (RW'(1) << QW) : RW'(w_q_a);
    assign c_rad_b = r_ctx[QW].sat_b ? (RW'(1) << QW) : RW'(w_q_b);

    plics_sqrt #(.OW(OW)) u_sqrt_a (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_rad  (c_rad_a),
        .o_root (w_s_a)
    );

    plics_sqrt #(.OW(OW)) u_sqrt_b (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_rad  (c_rad_b),
        .o_root (w_s_b)
    );

    // case II half-width rides beside the root stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_hw[0] <= w_q_a[F:0];
        end
    end

    for (genvar k = 1; k < OW; k++) begin : g_hw
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_hw[k] <= r_hw[k-1];
            end
        end
    end

    // ---- stage P1: endpoint positions from the low cell edges
    function automatic t_pos pk(input logic [F:0] a, input logic [F:0] b,
                                input logic [F:0] c, input logic [F:0] d);
        pk = {d, c, b, a};
    endfunction

    t_ctx       c6_ctx;
    logic [F:0] c6_hi, c6_lo, c6_y, c6_x, c6_a, c6_b;
    t_pos       c6_p;

    assign c6_ctx = r_ctx[QW+OW];
    assign c6_hi  = c6_ctx.ph + r_hw[OW-1];
    assign c6_lo  = c6_ctx.ph - r_hw[OW-1];
    assign c6_y   = c6_ctx.sy_pos ? U1 - c6_ctx.ph : c6_ctx.ph;
    assign c6_x   = c6_ctx.sx_pos ? U1 - c6_ctx.ph : c6_ctx.ph;
    assign c6_a   = w_s_a;   // leg along tn/td (lt or et)
    assign c6_b   = w_s_b;   // complementary leg (lc or ec)

    always_comb begin
        c6_p = '0;
        unique case (c6_ctx.kind)
            K_AXH: c6_p = pk(U1, c6_y, '0, c6_y);
            K_AXV: c6_p = pk(c6_x, U1, c6_x, '0);
            K_DIAG: begin
                unique case (c6_ctx.cse)
                    CASE_I: begin
                        unique case (c6_ctx.quad)
                            Q4: c6_p = pk(U1 - c6_b, '0, U1, c6_a);
                            Q3: c6_p = pk(c6_a, '0, '0, c6_b);
                            Q2: c6_p = pk(c6_b, U1, '0, U1 - c6_a);
                            Q1: c6_p = pk(U1 - c6_a, U1, U1, U1 - c6_b);
                            default: c6_p = '0;
                        endcase
                    end
                    CASE_II: begin
                        if (c6_ctx.tlt) begin
                            unique case (c6_ctx.quad)
                                Q4: c6_p = pk('0, c6_lo, U1, c6_hi);
                                Q3: c6_p = pk(c6_hi, '0, c6_lo, U1);
                                Q2: c6_p = pk('0, U1 - c6_hi, U1, U1 - c6_lo);
                                Q1: c6_p = pk(U1 - c6_hi, U1, U1 - c6_lo, '0);
                                default: c6_p = '0;
                            endcase
                        end else begin
                            unique case (c6_ctx.quad)
                                Q4: c6_p = pk(U1 - c6_hi, '0, U1 - c6_lo, U1);
                                Q3: c6_p = pk('0, c6_hi, U1, c6_lo);
                                Q2: c6_p = pk(c6_lo, '0, c6_hi, U1);
                                Q1: c6_p = pk('0, U1 - c6_lo, U1, U1 - c6_hi);
                                default: c6_p = '0;
                            endcase
                        end
                    end
                    CASE_III: begin
                        unique case (c6_ctx.quad)
                            Q4: c6_p = pk(c6_b, U1, '0, U1 - c6_a);
                            Q3: c6_p = pk(U1, U1 - c6_b, U1 - c6_a, U1);
                            Q2: c6_p = pk(U1, c6_a, U1 - c6_b, '0);
                            Q1: c6_p = pk(c6_a, '0, '0, c6_b);
                            default: c6_p = '0;
                        endcase
                    end
                    default: c6_p = '0;
                endcase
            end
            default: c6_p = '0;
        endcase
    end

    t_kind      r6_kind;
    t_pos       r6_p;
    logic [F:0] r6_w, r6_h;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_kind <= c6_ctx.kind;
            r6_p    <= c6_p;
            r6_w    <= c6_ctx.w;
            r6_h    <= c6_ctx.h;
        end
    end

    // ---- stage P2: scale to offsets from the centre, output register
    // offset = d*(2k - UNIT)/(2*UNIT), truncated toward zero
    function automatic logic [EW-1:0] place(input logic [F:0] k, input logic [F:0] d);
        logic signed [F+2:0] v;
        logic [F:0]          mg;
        logic [2*F+1:0]      pr;
        logic [EW-1:0]       r;
        v     = $signed({1'b0, k, 1'b0}) - $signed((F+3)'(U1));
        mg    = v[F+2] ? FW'(-v) : FW'(v);
        pr    = (2*F+2)'(mg) * (2*F+2)'(d);
        r     = EW'(pr >> (F + 1));
        place = v[F+2] ? -r : r;
    endfunction

    logic          c7_seg;
    logic [EW-1:0] r7_fx, r7_fy, r7_sx, r7_sy;
    logic [1:0]    r7_st;

    assign c7_seg = (r6_kind == K_AXH) || (r6_kind == K_AXV) || (r6_kind == K_DIAG);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r7_fx <= c7_seg ? place(r6_p[0], r6_w) : '0;
            r7_fy <= c7_seg ? place(r6_p[1], r6_h) : '0;
            r7_sx <= c7_seg ? place(r6_p[2], r6_w) : '0;
            r7_sy <= c7_seg ? place(r6_p[3], r6_h) : '0;
            if (c7_seg)                 r7_st <= ST_SEG;
            else if (r6_kind == K_ZERO) r7_st <= ST_ZERO;
            else                        r7_st <= ST_SKIP;
        end
    end

    assign o_m_axis_tdata = ODW'({r7_sy, r7_sx, r7_fy, r7_fx});
    assign o_m_axis_tuser = r7_st;

    // ---- checks
    a_nonseg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != ST_SEG) |-> (o_m_axis_tdata == '0))
        else $error("non-segment result carries nonzero offsets");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == ST_SKIP || o_m_axis_tuser == ST_SEG ||
                             o_m_axis_tuser == ST_ZERO))
        else $error("undefined status code");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |=> $stable(r_vld))
        else $error("pipe moved during a stall");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> r_vld[1])
        else $error("accepted request lost at entry");

endmodule

>>> test/tb.sv
// Testbench for plic_interface_segment: directed cells from a table, then random cells.
// Depends on plics_pkg and the RTL of plic_interface_segment; predicts all but typed rows.
`timescale 1ns / 1ps

module tb;
    import plics_pkg::*;

    localparam int FB    = 16;
    localparam int FW    = FB + 1;                     // input field width
    localparam int OW    = FB + 2;                     // output field width
    localparam int IDW   = ((11 * FW + 7) / 8) * 8;
    localparam int ODW   = ((4 * OW + 7) / 8) * 8;
    localparam longint UNIT = 64'd1 << FB;
    localparam int N_RANDOM   = 1800;
    localparam int HOLD_LEN   = 400;                   // long receiver hold-off, cycles
    localparam int DRAIN_WAIT = 3 * FB + 20;           // pipe latency plus margin
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]    status;
        logic [OW-1:0] x1, y1, x2, y2;
    } t_segment;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_s_axis_tvalid = 1'b0;
    logic            o_s_axis_tready;
    logic [IDW-1:0]  i_s_axis_tdata = '0;
    logic            o_m_axis_tvalid;
    logic            i_m_axis_tready = 1'b0;
    logic [ODW-1:0]  o_m_axis_tdata;
    logic [1:0]      o_m_axis_tuser;

    t_segment seg_q[$];          // expected segments, oldest first
    int       n_errors = 0;
    int       cycle_cnt = 0;
    bit       hold_req = 1'b0;   // asks the receiver for a long hold-off
    int       hold_cnt = 0;

    always #6 i_clk = ~i_clk;

    plic_interface_segment #(.FRACTION_BITS(FB)) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // ---------------- predictor ----------------
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // corner leg floor(sqrt(2*x*n/d)) in Q1.F, saturated to one
    function automatic longint corner_leg(longint unsigned x, longint unsigned n,
                                          longint unsigned d);
        longint unsigned u, q, r, rad, s;
        u = 2 * x * n;
        q = u / d;
        r = u % d;
        if (q >= UNIT) rad = UNIT * UNIT;
        else rad = q * UNIT + (r * UNIT) / d;
        s = int_sqrt(rad);
        if (s > UNIT) s = UNIT;
        return longint'(s);
    endfunction

    // position k from the low edge -> signed offset from the centre
    function automatic logic [OW-1:0] centre_offset(longint unsigned side, longint k);
        longint v, res;
        longint unsigned mag;
        v = 2 * k - UNIT;
        mag = longint'(v < 0 ? -v : v) * side;
        res = longint'(mag >> (FB + 1));
        if (v < 0) res = -res;
        return res[OW-1:0];
    endfunction

    function automatic t_segment predict_segment(logic [IDW-1:0] req_bits);
        longint unsigned f[9];
        longint unsigned w, h, ax, ay, tn, td, mn, mx, phu, e;
        longint p[4];
        longint sx, sy, ph, y, x, lt, lc, hw, hi, lo, et, ec;
        bit agree;
        int quad;
        t_segment s;
        s = '0;
        for (int i = 0; i < 9; i++) begin
            f[i] = req_bits[i*FW +: FW];
            if (f[i] > UNIT) f[i] = UNIT;
        end
        w = req_bits[9*FW +: FW];
        h = req_bits[10*FW +: FW];
        if (f[0] == 0 || f[0] >= UNIT) begin
            s.status = ST_SKIP;
            return s;
        end
        // 0 c, 1 e, 2 w, 3 n, 4 s, 5 ne, 6 nw, 7 se, 8 sw
        sx = longint'(f[5] + 2 * f[1] + f[7]) - longint'(f[6] + 2 * f[2] + f[8]);
        sy = longint'(f[5] + 2 * f[3] + f[6]) - longint'(f[7] + 2 * f[4] + f[8]);
        ph = longint'(f[0]);
        if (sx == 0 && sy == 0) begin
            s.status = ST_ZERO;
            return s;
        end
        if (sx == 0) begin
            y = sy > 0 ? UNIT - ph : ph;
            p = '{UNIT, y, 0, y};
        end else if (sy == 0) begin
            x = sx < 0 ? ph : UNIT - ph;
            p = '{x, UNIT, x, 0};
        end else begin
            ax = sx < 0 ? -sx : sx;
            ay = sy < 0 ? -sy : sy;
            agree = (sx > 0) == (sy > 0);
            tn = agree ? ay : ax;
            td = agree ? ax : ay;
            mn = tn < td ? tn : td;
            mx = tn < td ? td : tn;
            phu = ph;
            quad = sx > 0 ? (sy > 0 ? 1 : 4) : (sy > 0 ? 2 : 3);
            if (2 * phu * mx <= mn * UNIT) begin
                // small corner triangle
                lt = corner_leg(phu, tn, td);
                lc = corner_leg(phu, td, tn);
                case (quad)
                    4: p = '{UNIT - lc, 0, UNIT, lt};
                    3: p = '{lt, 0, 0, lc};
                    2: p = '{lc, UNIT, 0, UNIT - lt};
                    default: p = '{UNIT - lt, UNIT, UNIT, UNIT - lc};
                endcase
            end else if (2 * (UNIT - phu) * mx >= mn * UNIT) begin
                // trapezoid, line crosses two opposite sides
                hw = longint'((mn * UNIT) / (2 * mx));
                hi = ph + hw;
                lo = ph - hw;
                if (tn < td) begin
                    case (quad)
                        4: p = '{0, lo, UNIT, hi};
                        3: p = '{hi, 0, lo, UNIT};
                        2: p = '{0, UNIT - hi, UNIT, UNIT - lo};
                        default: p = '{UNIT - hi, UNIT, UNIT - lo, 0};
                    endcase
                end else begin
                    case (quad)
                        4: p = '{UNIT - hi, 0, UNIT - lo, UNIT};
                        3: p = '{0, hi, UNIT, lo};
                        2: p = '{lo, 0, hi, UNIT};
                        default: p = '{0, UNIT - lo, UNIT, UNIT - hi};
                    endcase
                end
            end else begin
                // nearly full, empty corner triangle
                e = UNIT - phu;
                et = corner_leg(e, tn, td);
                ec = corner_leg(e, td, tn);
                case (quad)
                    4: p = '{ec, UNIT, 0, UNIT - et};
                    3: p = '{UNIT, UNIT - ec, UNIT - et, UNIT};
                    2: p = '{UNIT, et, UNIT - ec, 0};
                    default: p = '{et, 0, 0, ec};
                endcase
            end
        end
        s.status = ST_SEG;
        s.x1 = centre_offset(w, p[0]);
        s.y1 = centre_offset(h, p[1]);
        s.x2 = centre_offset(w, p[2]);
        s.y2 = centre_offset(h, p[3]);
        return s;
    endfunction

    // ---------------- stimulus helpers ----------------
    // fields: c, e, w, n, s, ne, nw, se, sw, width, height
    function automatic logic [IDW-1:0] pack_cell(int c, int fe, int fw, int fn, int fs,
                                                 int fne, int fnw, int fse, int fsw,
                                                 int cw, int ch);
        logic [IDW-1:0] v;
        v = '0;
        v[0*FW +: FW] = c;   v[1*FW +: FW] = fe;  v[2*FW +: FW] = fw;
        v[3*FW +: FW] = fn;  v[4*FW +: FW] = fs;  v[5*FW +: FW] = fne;
        v[6*FW +: FW] = fnw; v[7*FW +: FW] = fse; v[8*FW +: FW] = fsw;
        v[9*FW +: FW] = cw;  v[10*FW +: FW] = ch;
        return v;
    endfunction

    function automatic int rand_frac();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return $urandom_range(65537, 131071);   // above one, clamps
        if (r < 12) return 0;
        if (r < 19) return 65536;
        return $urandom_range(0, 65536);
    endfunction

    function automatic int rand_side();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r == 1) return 131071;
        if (r == 2) return 65536;
        return $urandom_range(1, 131071);
    endfunction

    function automatic int clamp_frac(int v);
        if (v < 0) return 0;
        if (v > 65536) return 65536;
        return v;
    endfunction

    function automatic logic [IDW-1:0] rand_cell();
        int c, r, a, b, base, g;
        int nb[8];
        r = $urandom_range(0, 99);
        // centre: mostly interior, some near the edges for the corner cases
        if (r < 4) c = 0;
        else if (r < 8) c = 65536;
        else if (r < 10) c = $urandom_range(65537, 131071);
        else if (r < 25) c = $urandom_range(1, 3000);
        else if (r < 40) c = $urandom_range(62536, 65535);
        else c = $urandom_range(1, 65535);
        for (int i = 0; i < 8; i++) nb[i] = rand_frac();
        g = $urandom_range(0, 99);
        if (g < 5) begin
            // uniform field, zero normal
            for (int i = 0; i < 8; i++) nb[i] = nb[0];
        end else if (g < 12) begin
            // mirror left/right: Sx zero
            nb[1] = nb[0]; nb[5] = nb[4]; nb[7] = nb[6];
        end else if (g < 19) begin
            // mirror top/bottom: Sy zero
            nb[3] = nb[2]; nb[6] = nb[4]; nb[7] = nb[5];
        end else if (g < 75) begin
            // smooth linear field, e w n s ne nw se sw
            base = $urandom_range(0, 65536);
            a = $urandom_range(0, 60000) - 30000;
            b = $urandom_range(0, 60000) - 30000;
            if ($urandom_range(0, 3) == 0) a = a / 64;
            if ($urandom_range(0, 3) == 0) b = b / 64;
            nb[0] = clamp_frac(base + a);     nb[1] = clamp_frac(base - a);
            nb[2] = clamp_frac(base + b);     nb[3] = clamp_frac(base - b);
            nb[4] = clamp_frac(base + a + b); nb[5] = clamp_frac(base - a + b);
            nb[6] = clamp_frac(base + a - b); nb[7] = clamp_frac(base - a - b);
        end
        return pack_cell(c, nb[0], nb[1], nb[2], nb[3], nb[4], nb[5], nb[6], nb[7],
                         rand_side(), rand_side());
    endfunction

    // one request: hold valid until accepted, then log the expectation
    task automatic send_cell(logic [IDW-1:0] req_bits, t_segment exp_seg);
        i_s_axis_tdata  <= req_bits;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        seg_q.push_back(exp_seg);
    endtask

    task automatic idle_cycles(int n);
        if (n > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // ---------------- receiver and checker ----------------
    always @(posedge i_clk) begin
        t_segment got, want;
        int phase;
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            got.status = o_m_axis_tuser;
            got.x1 = o_m_axis_tdata[0*OW +: OW];
            got.y1 = o_m_axis_tdata[1*OW +: OW];
            got.x2 = o_m_axis_tdata[2*OW +: OW];
            got.y2 = o_m_axis_tdata[3*OW +: OW];
            if (seg_q.size() == 0) begin
                $display("%0t: result with nothing expected: st=%0d x1=%0d y1=%0d x2=%0d y2=%0d",
                         $time, got.status, $signed(got.x1), $signed(got.y1),
                         $signed(got.x2), $signed(got.y2));
                n_errors++;
            end else begin
                want = seg_q.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             got.status);
                    n_errors++;
                end
                if (got.x1 !== want.x1) begin
                    $display("%0t: first_x expected %0d actual %0d", $time,
                             $signed(want.x1), $signed(got.x1));
                    n_errors++;
                end
                if (got.y1 !== want.y1) begin
                    $display("%0t: first_y expected %0d actual %0d", $time,
                             $signed(want.y1), $signed(got.y1));
                    n_errors++;
                end
                if (got.x2 !== want.x2) begin
                    $display("%0t: second_x expected %0d actual %0d", $time,
                             $signed(want.x2), $signed(got.x2));
                    n_errors++;
                end
                if (got.y2 !== want.y2) begin
                    $display("%0t: second_y expected %0d actual %0d", $time,
                             $signed(want.y2), $signed(got.y2));
                    n_errors++;
                end
            end
        end
        // ready pattern: free-running, random, mostly stalled; or a long hold-off
        phase = (cycle_cnt / 250) % 3;
        if (hold_req && hold_cnt < HOLD_LEN) begin
            hold_cnt <= hold_cnt + 1;
            i_m_axis_tready <= 1'b0;
        end else if (phase == 0) begin
            i_m_axis_tready <= 1'b1;
        end else if (phase == 1) begin
            i_m_axis_tready <= $urandom_range(0, 1);
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------- main sequence ----------------
    typedef struct {
        logic [IDW-1:0] req_bits;
        bit             typed;   // expected result given in the row
        t_segment       seg;
    } t_row;

    initial begin
        t_row rows[$];
        t_segment none;
        int burst, gap;
        bit drained;
        none = '0;
        drained = 1'b0;
        // skipped cells
        rows.push_back('{pack_cell(0, 65536, 0, 65536, 0, 65536, 0, 65536, 0, 65536, 65536),
                         1, '{ST_SKIP, 0, 0, 0, 0}});
        rows.push_back('{pack_cell(65536, 0, 65536, 0, 65536, 0, 65536, 0, 65536, 131071,
                                   131071), 1, '{ST_SKIP, 0, 0, 0, 0}});
        // fraction above one clamps to full
        rows.push_back('{pack_cell(131071, 1, 2, 3, 4, 5, 6, 7, 8, 65536, 65536),
                         1, '{ST_SKIP, 0, 0, 0, 0}});
        // zero normal
        rows.push_back('{pack_cell(32768, 0, 0, 0, 0, 0, 0, 0, 0, 65536, 65536),
                         1, '{ST_ZERO, 0, 0, 0, 0}});
        rows.push_back('{pack_cell(1, 131071, 65536, 131071, 65536, 131071, 131071, 131071,
                                   131071, 1, 1), 1, '{ST_ZERO, 0, 0, 0, 0}});
        // Sx zero, Sy > 0: horizontal segment at mid height
        rows.push_back('{pack_cell(32768, 0, 0, 65536, 0, 0, 0, 0, 0, 65536, 65536),
                         1, '{ST_SEG, 18'sd32768, 18'sd0, -18'sd32768, 18'sd0}});
        // Sx zero, Sy < 0; Sy zero both signs
        rows.push_back('{pack_cell(1000, 0, 0, 0, 65536, 0, 0, 0, 0, 131071, 131071), 0, none});
        rows.push_back('{pack_cell(65535, 65536, 0, 0, 0, 0, 0, 0, 0, 131071, 1), 0, none});
        rows.push_back('{pack_cell(20000, 0, 65536, 0, 0, 0, 0, 0, 0, 1, 131071), 0, none});
        // zero cell sides
        rows.push_back('{pack_cell(20000, 0, 65536, 0, 30000, 0, 0, 0, 0, 0, 65536), 0, none});
        rows.push_back('{pack_cell(50000, 40000, 0, 0, 30000, 0, 0, 0, 0, 65536, 0), 0, none});
        // diagonal: corner triangle, trapezoid, near-full, every quadrant
        rows.push_back('{pack_cell(1, 65536, 0, 65536, 0, 65536, 0, 0, 0, 65536, 65536), 0, none});
        rows.push_back('{pack_cell(32768, 0, 65536, 30000, 0, 0, 0, 0, 0, 65536, 65536), 0, none});
        rows.push_back('{pack_cell(65535, 0, 65536, 0, 65536, 0, 0, 0, 65536, 65536, 65536),
                         0, none});
        rows.push_back('{pack_cell(40000, 65536, 0, 0, 65536, 0, 0, 0, 0, 90000, 70000), 0, none});
        rows.push_back('{pack_cell(3000, 0, 20000, 65536, 0, 0, 0, 0, 0, 131071, 131071), 0, none});
        rows.push_back('{pack_cell(64000, 10000, 0, 0, 60000, 0, 0, 0, 0, 131071, 131071), 0, none});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i])
            send_cell(rows[i].req_bits,
                      rows[i].typed ? rows[i].seg : predict_segment(rows[i].req_bits));

        // random part in bursts
        for (int n = 0; n < N_RANDOM; ) begin
            if (n >= 600 && !hold_req) hold_req = 1'b1;   // sender keeps offering
            if (n >= 1200 && !drained) begin
                // pause until the pipe has drained
                i_s_axis_tvalid <= 1'b0;
                while (seg_q.size() != 0) @(posedge i_clk);
                drained = 1'b1;
            end
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n < N_RANDOM; k++) begin
                logic [IDW-1:0] req_bits;
                req_bits = rand_cell();
                send_cell(req_bits, predict_segment(req_bits));
                n++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            idle_cycles(gap);
        end
        i_s_axis_tvalid <= 1'b0;

        while (seg_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
